// ===== design/nearest_point_vol_lookup_assert.svh =====
// Assertion macros shared by the nearest-point volatility lookup modules.
`ifndef NEAREST_POINT_VOL_LOOKUP_ASSERT_SVH
`define NEAREST_POINT_VOL_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define NPVL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NPVL_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NPVL_ASSERT(label, clk, rst_n, prop, msg)
`define NPVL_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/npvl_pkg.sv =====
// Types, sizes and codes shared by the nearest-point volatility lookup modules.
package npvl_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COORD_W  = 24;
    localparam int VOL_W    = 20;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int DIST_W   = SQ_W + 1;

    localparam logic [VOL_W-1:0] EMPTY_VOL_RST = 20'd13107;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_e_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_e_t;

    typedef struct packed {
        logic [COORD_W-1:0] strike;
        logic [COORD_W-1:0] expiry;
        logic [VOL_W-1:0]   vol;
    } point_t;

    // One table entry offered to the distance unit.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        point_t           pt;
    } scan_in_t;

    // Running result of the search.
    typedef struct packed {
        logic             busy;
        logic             have;
        logic [IDX_W-1:0] idx;
        logic [VOL_W-1:0] vol;
    } search_t;

endpackage

// ===== design/npvl_cell.sv =====
// One table entry of the rotating point ring.
module npvl_cell (
    input  logic            aclk,
    input  logic            shift_en,
    input  logic            load_en,
    input  npvl_pkg::point_t load_pt,
    input  npvl_pkg::point_t nbr_pt,
    output npvl_pkg::point_t pt
);
    import npvl_pkg::*;

    point_t pt_reg;

    // A new point lands here on append; during a search the entry moves one
    // place toward the head of the ring each cycle.
    always_ff @(posedge aclk) begin
        if (load_en) begin
            pt_reg <= load_pt;
        end else if (shift_en) begin
            pt_reg <= nbr_pt;
        end
    end

    assign pt = pt_reg;

endmodule

// ===== design/npvl_dist.sv =====
// Pipelined squared-distance unit with running minimum for the point search.
`include "nearest_point_vol_lookup_assert.svh"
module npvl_dist (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 clr,
    input  npvl_pkg::scan_in_t                   scan_in,
    input  logic [npvl_pkg::COORD_W-1:0]         q_strike,
    input  logic [npvl_pkg::COORD_W-1:0]         q_expiry,
    output npvl_pkg::search_t                    search
);
    import npvl_pkg::*;

    logic               v1_reg, v2_reg;
    logic [COORD_W-1:0] dk_reg, dt_reg;
    logic [IDX_W-1:0]   idx1_reg, idx2_reg;
    logic [VOL_W-1:0]   vol1_reg, vol2_reg;
    logic [SQ_W-1:0]    sqk_reg, sqt_reg;
    logic               have_reg, have_next;
    logic [DIST_W-1:0]  best_reg, best_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [VOL_W-1:0]   best_vol_reg, best_vol_next;
    logic [COORD_W-1:0] dk, dt;
    logic [DIST_W-1:0]  cand_dist;

    always_comb begin
        dk = (scan_in.pt.strike >= q_strike) ? scan_in.pt.strike - q_strike
                                             : q_strike - scan_in.pt.strike;
        dt = (scan_in.pt.expiry >= q_expiry) ? scan_in.pt.expiry - q_expiry
                                             : q_expiry - scan_in.pt.expiry;
    end

    assign cand_dist = {1'b0, sqk_reg} + {1'b0, sqt_reg};

    // Strict less-than keeps the lowest index on equal distances.
    always_comb begin
        have_next     = have_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        best_vol_next = best_vol_reg;
        if (clr) begin
            have_next = 1'b0;
        end else if (v2_reg && (!have_reg || cand_dist < best_reg)) begin
            have_next     = 1'b1;
            best_next     = cand_dist;
            best_idx_next = idx2_reg;
            best_vol_next = vol2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            have_reg <= 1'b0;
        end else begin
            v1_reg   <= scan_in.valid;
            v2_reg   <= v1_reg;
            have_reg <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        dk_reg       <= dk;
        dt_reg       <= dt;
        idx1_reg     <= scan_in.idx;
        vol1_reg     <= scan_in.pt.vol;
        sqk_reg      <= SQ_W'(dk_reg) * SQ_W'(dk_reg);
        sqt_reg      <= SQ_W'(dt_reg) * SQ_W'(dt_reg);
        idx2_reg     <= idx1_reg;
        vol2_reg     <= vol1_reg;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        best_vol_reg <= best_vol_next;
    end

    assign search.busy = v1_reg | v2_reg;
    assign search.have = have_reg;
    assign search.idx  = best_idx_reg;
    assign search.vol  = best_vol_reg;

    // Entries arrive in table order, so any candidate follows the current best.
    `NPVL_ASSERT(a_idx_order, aclk, aresetn, (v2_reg && have_reg) |-> (idx2_reg > best_idx_reg), "candidate index does not follow best index")
    // A new search starts only with the pipeline empty.
    `NPVL_NEVER(a_clr_idle, aclk, aresetn, clr && (v1_reg || v2_reg), "search restarted while pipeline busy")
    // Every candidate that enters the square stage reaches the compare stage.
    `NPVL_ASSERT(a_stage_follow, aclk, aresetn, v1_reg |=> v2_reg, "distance stage dropped a candidate")

endmodule

// ===== design/nearest_point_vol_lookup.sv =====
// Top level of the nearest-point volatility lookup: control, point ring and output register.
//
//  Channel  | Ports                    | Item contents
//  ---------+--------------------------+------------------------------------------------
//  input    | s_tvalid/s_tready        | tuser: operation; tdata: strike, expiry, vol_in
//  result   | m_tvalid/m_tready        | tuser: status; tdata: vol_out, nearest_index
//  config   | cfg_we/cfg_wdata         | empty_vol fallback volatility
//
// Clear, append, unknown operations and a query on an empty table give their
// result in the cycle after the item is taken, one item per cycle unless the
// result stalls. A query on a non-empty table rotates the whole ring of CAPACITY
// cells past one distance unit, then drains the distance pipeline.
// The block takes an item only while idle and while its output register is free
// or being emptied in the same cycle; a stalled result holds the next item off.
// Reset clears the point count and the control state and restores the fallback
// volatility to 0.2; the table contents stay undefined until appended.
`include "nearest_point_vol_lookup_assert.svh"
module nearest_point_vol_lookup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,   // empty_vol
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,     // strike [23:0], expiry [47:24], vol_in [67:48], zeros
    input  logic [1:0]  s_tuser,     // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // vol_out [19:0], nearest_index [27:20], zeros
    output logic [1:0]  m_tuser      // status [1:0]
);
    import npvl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [VOL_W-1:0]   empty_vol_reg;
    logic [COORD_W-1:0] q_strike_reg, q_expiry_reg;
    logic               m_valid_reg, m_valid_next;
    status_e_t          m_status_reg, m_status_next;
    logic [VOL_W-1:0]   m_vol_reg, m_vol_next;
    logic [7:0]         m_idx_reg, m_idx_next;

    logic               out_free, s_acc, append_go, query_go, scan_go;
    op_e_t              op;
    point_t             in_pt;
    point_t             ring [CAPACITY];
    logic [CAPACITY-1:0] load_vec;
    scan_in_t           scan_in;
    search_t            search;

    assign op       = op_e_t'(s_tuser);
    assign in_pt    = '{strike: s_tdata[23:0], expiry: s_tdata[47:24], vol: s_tdata[67:48]};
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign scan_go  = (state_reg == S_SCAN);

    // Write the configuration register only while idle; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_vol_reg <= EMPTY_VOL_RST;
        end else if (cfg_we) begin
            empty_vol_reg <= cfg_wdata;
        end
    end

    // Control: the operation decode for items taken in idle, the ring rotation
    // during a search, and the loading of the result register.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        append_go     = 1'b0;
        query_go      = 1'b0;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;
        m_status_next = m_status_reg;
        m_vol_next    = m_vol_reg;
        m_idx_next    = m_idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_vol_next    = '0;
                    m_idx_next    = '0;
                    case (op)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_APPEND: begin
                            if (count_reg < CNT_W'(CAPACITY)) begin
                                append_go  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end else begin
                                m_status_next = STAT_FULL;
                            end
                        end
                        OP_QUERY: begin
                            if (count_reg == '0) begin
                                m_status_next = STAT_EMPTY;
                                m_vol_next    = empty_vol_reg;
                            end else begin
                                // No result yet: the search takes the ring around.
                                m_valid_next = 1'b0;
                                query_go     = 1'b1;
                                pos_next     = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        default: begin
                            // The spare operation code leaves the table alone.
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (pos_reg == IDX_W'(CAPACITY - 1)) begin
                    pos_next   = '0;
                    state_next = S_DRAIN;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!search.busy && out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_vol_next    = search.vol;
                    m_idx_next    = 8'(search.idx);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_vol_reg    <= m_vol_next;
        m_idx_reg    <= m_idx_next;
        if (query_go) begin
            q_strike_reg <= in_pt.strike;
            q_expiry_reg <= in_pt.expiry;
        end
    end

    // An append writes the cell at the current fill level.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            load_vec[i] = append_go && (IDX_W'(count_reg) == IDX_W'(i));
        end
    end

    // The ring: each cell takes its upper neighbor's entry while searching, so
    // at scan step n the head cell holds entry n. After CAPACITY steps every
    // entry is back in its own cell.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        npvl_cell u_cell (
            .aclk     (aclk),
            .shift_en (scan_go),
            .load_en  (load_vec[gi]),
            .load_pt  (in_pt),
            .nbr_pt   (ring[(gi + 1) % CAPACITY]),
            .pt       (ring[gi])
        );
    end

    // Entries at or beyond the fill level go past the unit without counting.
    assign scan_in.valid = scan_go && (CNT_W'(pos_reg) < count_reg);
    assign scan_in.idx   = pos_reg;
    assign scan_in.pt    = ring[0];

    npvl_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr      (query_go),
        .scan_in  (scan_in),
        .q_strike (q_strike_reg),
        .q_expiry (q_expiry_reg),
        .search   (search)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_idx_reg, m_vol_reg};
    assign m_tuser  = m_status_reg;

    `NPVL_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY), "point count beyond capacity")
    `NPVL_ASSERT(a_drain_have, aclk, aresetn, (state_reg == S_DRAIN && !search.busy) |-> search.have, "search ended without a candidate")
    `NPVL_ASSERT(a_pos_idle, aclk, aresetn, (state_reg != S_SCAN) |-> (pos_reg == '0), "scan position moved outside a search")
    `NPVL_ASSERT(a_scan_count, aclk, aresetn, (state_reg == S_SCAN) |-> (count_reg != '0), "search running on an empty table")

endmodule

// ===== tb/nearest_point_vol_lookup_test.sv =====
// Self-checking testbench for the nearest-point volatility lookup table.
module nearest_point_vol_lookup_test;
    import npvl_pkg::*;

    // Operation code 3 has no meaning; the block must answer it with an all-zero result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Generous bound on the run; the slowest legal run stays well below it.
    localparam int CYCLE_LIMIT = 4_000_000;
    // A query walks all CAPACITY ring cells plus a short pipeline drain.
    localparam int QUERY_LATENCY = CAPACITY + 16;
    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam logic [VOL_W-1:0]   VOL_MAX   = '1;

    // One expected result item.
    typedef struct {
        status_e_t        status;
        logic [VOL_W-1:0] vol;
        logic [7:0]       index;
    } lookup_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [19:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;    // strike [23:0], expiry [47:24], vol_in [67:48], zeros
    logic [1:0]  s_tuser = '0;    // operation [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // vol_out [19:0], nearest_index [27:20], zeros
    logic [1:0]  m_tuser;         // status [1:0]

    // Own copy of the point table, the point count and the fallback volatility.
    logic [COORD_W-1:0] table_strike [CAPACITY];
    logic [COORD_W-1:0] table_expiry [CAPACITY];
    logic [VOL_W-1:0]   table_vol    [CAPACITY];
    int unsigned        point_count = 0;
    logic [VOL_W-1:0]   fallback_vol = EMPTY_VOL_RST;

    // Results still owed by the block, oldest first.
    lookup_result_t lookups_due[$];

    // Idle rates in percent and the long receiver hold-off, in cycles.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned recv_hold_left = 0;

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned searches_done = 0;
    int unsigned empty_queries = 0;
    int unsigned dropped_appends = 0;
    int unsigned tie_queries = 0;
    int unsigned fallback_writes = 0;

    nearest_point_vol_lookup i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Works out the result of one item and updates the table copy. A query keeps
    // the first entry with the smallest exact squared distance, so ties go to the
    // lowest index.
    function automatic lookup_result_t predict_lookup(logic [1:0] op, logic [COORD_W-1:0] k,
                                                      logic [COORD_W-1:0] t,
                                                      logic [VOL_W-1:0] v);
        lookup_result_t  res;
        longint unsigned dk;
        longint unsigned dt;
        longint unsigned sq_dist;
        longint unsigned best;
        int unsigned     winner;
        bit              tied;
        res.status = STAT_OK;
        res.vol = '0;
        res.index = '0;
        best = 0;
        winner = 0;
        tied = 1'b0;
        case (op)
            OP_CLEAR: begin
                point_count = 0;
            end
            OP_APPEND: begin
                if (point_count < CAPACITY) begin
                    table_strike[point_count] = k;
                    table_expiry[point_count] = t;
                    table_vol[point_count] = v;
                    point_count++;
                end else begin
                    res.status = STAT_FULL;
                    dropped_appends++;
                end
            end
            OP_QUERY: begin
                if (point_count == 0) begin
                    res.status = STAT_EMPTY;
                    res.vol = fallback_vol;
                    empty_queries++;
                end else begin
                    for (int unsigned i = 0; i < point_count; i++) begin
                        dk = (table_strike[i] >= k) ? longint'(table_strike[i] - k)
                                                    : longint'(k - table_strike[i]);
                        dt = (table_expiry[i] >= t) ? longint'(table_expiry[i] - t)
                                                    : longint'(t - table_expiry[i]);
                        sq_dist = dk * dk + dt * dt;
                        if (i == 0 || sq_dist < best) begin
                            best = sq_dist;
                            winner = i;
                        end else if (sq_dist == best) begin
                            tied = 1'b1;
                        end
                    end
                    res.vol = table_vol[winner];
                    res.index = winner[7:0];
                    searches_done++;
                    if (tied)
                        tie_queries++;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("tb: mismatch on %s at cycle %0d: got %0h, expected %0h",
                     field, cycle_count, got, want);
    endtask

    // Offers one item at the falling edge, after an optional random gap, and holds
    // it until the block takes it. The expectation is queued at the accepting edge.
    task automatic send_item(logic [1:0] op, logic [COORD_W-1:0] k, logic [COORD_W-1:0] t,
                             logic [VOL_W-1:0] v);
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {4'b0000, v, t, k};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        lookups_due.insert(lookups_due.size(), predict_lookup(op, k, t, v));
        items_sent++;
    endtask

    // The sender stops and waits until every owed result is back. Every item gives
    // exactly one result, so the block is idle then; the task waits on before it returns.
    task automatic drain_lookups();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (lookups_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes the fallback volatility while the block is idle.
    task automatic write_fallback_vol(logic [VOL_W-1:0] value);
        drain_lookups();
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        fallback_vol = value;
        fallback_writes++;
    endtask

    // Coordinates from the extremes, from a tiny range (many equal distances),
    // or from the whole range.
    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(3))
            0: return COORD_W'($urandom_range(0, 15));
            1: return COORD_MAX - COORD_W'($urandom_range(0, 15));
            default: return COORD_W'($urandom());
        endcase
    endfunction

    function automatic logic [VOL_W-1:0] random_vol();
        case ($urandom_range(9))
            0: return '0;
            1: return VOL_MAX;
            default: return VOL_W'($urandom());
        endcase
    endfunction

    // A coordinate at most three steps from a stored one, wrapping at the range ends.
    function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] c);
        return c + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
    endfunction

    // Queries the fallback before any register write, then the reset-time
    // behavior of clear and the unused code on an empty table.
    task automatic test_reset_state();
        send_item(OP_QUERY, '0, '0, '0);
        send_item(OP_UNUSED, COORD_MAX, COORD_MAX, VOL_MAX);
        send_item(OP_CLEAR, 24'h123456, 24'h654321, 20'hABCDE);
        send_item(OP_QUERY, COORD_MAX, COORD_MAX, VOL_MAX);
    endtask

    // Hand-picked points: range extremes, exact hits, equal distances that must
    // resolve to the lowest index, duplicates, and an unused code between queries.
    task automatic test_directed_points();
        send_item(OP_APPEND, '0, '0, '0);
        send_item(OP_APPEND, COORD_MAX, COORD_MAX, VOL_MAX);
        send_item(OP_QUERY, '0, '0, 20'h55555);
        send_item(OP_QUERY, COORD_MAX, COORD_MAX, '0);
        // Both corners are equally far from the off-diagonal corners.
        send_item(OP_QUERY, COORD_MAX, '0, '0);
        send_item(OP_QUERY, '0, COORD_MAX, '0);
        // A duplicate of the first point must never win over it.
        send_item(OP_APPEND, '0, '0, 20'h12345);
        send_item(OP_QUERY, 24'd1, 24'd1, '0);
        // Two points mirrored about the query point.
        send_item(OP_APPEND, 24'd1000, 24'd500, 20'hAAAAA);
        send_item(OP_APPEND, 24'd3000, 24'd500, 20'h55555);
        send_item(OP_QUERY, 24'd2000, 24'd500, '0);
        send_item(OP_QUERY, 24'd2001, 24'd500, '0);
        send_item(OP_APPEND, 24'hAAAAAA, 24'h555555, 20'hAAAAA);
        send_item(OP_APPEND, 24'h555555, 24'hAAAAAA, 20'h55555);
        send_item(OP_UNUSED, 24'h555555, 24'hAAAAAA, 20'h55555);
        send_item(OP_QUERY, 24'h555555, 24'hAAAAAA, '0);
        send_item(OP_QUERY, 24'hAAAAAA, 24'h555555, '0);
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_QUERY, 24'd1000, 24'd500, '0);
    endtask

    // The fallback register at both extremes and at a random value.
    task automatic test_fallback_register();
        write_fallback_vol('0);
        send_item(OP_QUERY, 24'd7, 24'd9, '0);
        write_fallback_vol(VOL_MAX);
        send_item(OP_QUERY, COORD_MAX, '0, '0);
        write_fallback_vol(random_vol());
        send_item(OP_QUERY, random_coord(), random_coord(), '0);
    endtask

    // Fills every slot, then checks that further appends are dropped and that
    // the last slot can win a search.
    task automatic test_full_table();
        logic [COORD_W-1:0] k;
        logic [COORD_W-1:0] t;
        send_item(OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < CAPACITY; i++)
            send_item(OP_APPEND, random_coord(), random_coord(), random_vol());
        send_item(OP_APPEND, 24'd5, 24'd5, 20'h00001);
        send_item(OP_APPEND, COORD_MAX, COORD_MAX, VOL_MAX);
        k = table_strike[CAPACITY-1];
        t = table_expiry[CAPACITY-1];
        send_item(OP_QUERY, k, t, '0);
        send_item(OP_QUERY, nudge(k), nudge(t), '0);
        send_item(OP_QUERY, random_coord(), random_coord(), '0);
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_QUERY, k, t, '0);
    endtask

    // The receiver refuses results for a long stretch while the sender keeps
    // offering items, so the output register fills and the input stalls.
    task automatic test_result_backpressure();
        @(negedge aclk);
        s_tvalid = 1'b0;
        recv_hold_left = 600;
        send_item(OP_APPEND, 24'd100, 24'd200, 20'h00100);
        send_item(OP_QUERY, 24'd90, 24'd210, '0);
        for (int i = 0; i < 10; i++)
            send_item(OP_APPEND, random_coord(), random_coord(), random_vol());
        send_item(OP_QUERY, random_coord(), random_coord(), '0);
        drain_lookups();
    endtask

    // Random traffic. Appends and queries dominate; clears keep the table mostly
    // small. Queries aim mostly at or near stored points so that close calls and
    // equal distances are common. The unused code is noise and is not counted.
    task automatic test_random_traffic(int unsigned n_items);
        int unsigned        done;
        int unsigned        r;
        int unsigned        pick;
        logic [COORD_W-1:0] k;
        logic [COORD_W-1:0] t;
        done = 0;
        while (done < n_items) begin
            r = $urandom_range(99);
            if (r < 4) begin
                send_item(OP_CLEAR, random_coord(), random_coord(), random_vol());
                done++;
            end else if (r < 7) begin
                send_item(OP_UNUSED, random_coord(), random_coord(), random_vol());
            end else if (r < ((point_count == 0) ? 85 : 52)) begin
                if (point_count != 0 && $urandom_range(3) == 0) begin
                    pick = $urandom_range(point_count - 1);
                    k = nudge(table_strike[pick]);
                    t = nudge(table_expiry[pick]);
                end else begin
                    k = random_coord();
                    t = random_coord();
                end
                send_item(OP_APPEND, k, t, random_vol());
                done++;
            end else begin
                if (point_count != 0 && $urandom_range(3) != 0) begin
                    pick = $urandom_range(point_count - 1);
                    k = table_strike[pick];
                    t = table_expiry[pick];
                    if ($urandom_range(1) == 0) begin
                        k = nudge(k);
                        t = nudge(t);
                    end
                end else begin
                    k = random_coord();
                    t = random_coord();
                end
                send_item(OP_QUERY, k, t, random_vol());
                done++;
            end
        end
    endtask

    // Compares each accepted result with the oldest owed one.
    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (lookups_due.size() == 0) begin
                report_mismatch("unexpected result", {m_tuser, m_tdata[29:0]}, '0);
            end else begin
                want = lookups_due.pop_front();
                results_checked++;
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[19:0] !== want.vol)
                    report_mismatch("vol_out", 32'(m_tdata[19:0]), 32'(want.vol));
                if (m_tdata[27:20] !== want.index)
                    report_mismatch("nearest_index", 32'(m_tdata[27:20]), 32'(want.index));
            end
        end
    end

    // The receiver: a counted hold-off when one is requested, else random stalls.
    always @(negedge aclk) begin
        if (recv_hold_left > 0) begin
            recv_hold_left = recv_hold_left - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Sender seldom idle, receiver mostly stalled.
        send_idle_pct = 12;
        recv_idle_pct = 78;
        test_reset_state();
        test_directed_points();
        test_fallback_register();
        test_full_table();
        test_result_backpressure();
        test_random_traffic(420);

        // Sender mostly idle, receiver seldom stalled.
        write_fallback_vol(EMPTY_VOL_RST);
        send_idle_pct = 78;
        recv_idle_pct = 12;
        test_random_traffic(420);

        // Full rate on both sides.
        write_fallback_vol(random_vol());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(420);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (lookups_due.size() != 0)
            @(posedge aclk);
        repeat (QUERY_LATENCY) @(posedge aclk);

        $display("tb: %0d items sent, %0d results checked, %0d table searches (%0d with ties)",
                 items_sent, results_checked, searches_done, tie_queries);
        $display("tb: %0d empty-table queries, %0d dropped appends, %0d fallback writes",
                 empty_queries, dropped_appends, fallback_writes);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
